// ===== hw/rtl/i2c_master_byte_engine_defines.svh =====
// Assertion macros shared by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IME_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/i2cme_pkg.sv =====
// Package with the types and constants of the I2C master byte engine.
package i2cme_pkg;

  // Command codes; the values match the mode field encoding.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WACK  = 3'd5,
    CMD_NACK  = 3'd6
  } cmd_t;

  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_WRITE   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;
  localparam logic [2:0] MODE_WACK    = 3'd5;
  localparam logic [2:0] MODE_NACK    = 3'd6;

  localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       ack_timed_out;
  } rsp_t;

  // Classified tick as it travels from the front to the back.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/i2cme_front.sv =====
// Front stage: accepts ticks and decodes the mode field into a command.
module i2cme_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  i2cme_pkg::req_t    req,
  input  i2cme_pkg::q_status_t q_status,
  output logic               push,
  output i2cme_pkg::tick_t   push_tick
);

  logic             held;
  i2cme_pkg::tick_t tick;
  i2cme_pkg::cmd_t  cmd_dec;

  // Modes outside the command set decode to no command.
  always_comb begin
    case (req.mode)
      i2cme_pkg::MODE_START: cmd_dec = i2cme_pkg::CMD_START;
      i2cme_pkg::MODE_STOP:  cmd_dec = i2cme_pkg::CMD_STOP;
      i2cme_pkg::MODE_WRITE: cmd_dec = i2cme_pkg::CMD_WRITE;
      i2cme_pkg::MODE_READ:  cmd_dec = i2cme_pkg::CMD_READ;
      i2cme_pkg::MODE_WACK:  cmd_dec = i2cme_pkg::CMD_WACK;
      i2cme_pkg::MODE_NACK:  cmd_dec = i2cme_pkg::CMD_NACK;
      default:               cmd_dec = i2cme_pkg::CMD_IDLE;
    endcase
  end

  assign push      = held && !q_status.full;
  assign push_tick = tick;
  assign req_ready = !held || !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req_valid && req_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      tick.cmd        <= cmd_dec;
      tick.write_data <= req.write_data;
      tick.sda_sample <= req.sda_sample;
    end
  end

endmodule

// ===== hw/rtl/i2cme_queue.sv =====
// Short queue of decoded ticks between the front and the back.
module i2cme_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  i2cme_pkg::tick_t     push_tick,
  input  logic                 pop,
  output i2cme_pkg::tick_t     head,
  output i2cme_pkg::q_status_t q_status
);

  i2cme_pkg::tick_t                   entries [i2cme_pkg::QUEUE_DEPTH];
  logic [i2cme_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [i2cme_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [i2cme_pkg::QUEUE_CNT_W-1:0]  count;

  assign q_status.full  = (count == i2cme_pkg::QUEUE_CNT_W'(i2cme_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == i2cme_pkg::QUEUE_PTR_W'(i2cme_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == i2cme_pkg::QUEUE_PTR_W'(i2cme_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tick;
    end
  end

endmodule

// ===== hw/rtl/i2cme_back.sv =====
// Back stage: the bus sequencer, the held results and the output register.
module i2cme_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_enable,
  input  logic [7:0]           cfg_write_data,
  input  i2cme_pkg::tick_t     head,
  input  i2cme_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output i2cme_pkg::rsp_t      rsp
);

  logic [7:0]      ack_wait_limit;

  i2cme_pkg::cmd_t active_command, active_command_next;
  logic [1:0]      bit_phase, bit_phase_next;
  logic [3:0]      bit_count, bit_count_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic [7:0]      poll_count, poll_count_next;
  logic            clock_line, clock_line_next;
  logic            data_line, data_line_next;
  logic            data_drive, data_drive_next;
  logic [7:0]      held_read, held_read_next;
  logic            held_ack, held_ack_next;
  logic            held_timeout, held_timeout_next;
  logic            done;
  logic [3:0]      count_inc;

  // One tick is carried out when one is queued and the output slot is free or being emptied.
  assign pop = !q_status.empty && (!rsp_valid || rsp_ready);

  always_comb begin
    active_command_next = active_command;
    bit_phase_next      = bit_phase;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    poll_count_next     = poll_count;
    clock_line_next     = clock_line;
    data_line_next      = data_line;
    data_drive_next     = data_drive;
    held_read_next      = held_read;
    held_ack_next       = held_ack;
    held_timeout_next   = held_timeout;
    done                = 1'b0;
    count_inc           = bit_count + 4'd1;

    // A new command is only taken while idle; it runs its first tick now.
    if (active_command == i2cme_pkg::CMD_IDLE && head.cmd != i2cme_pkg::CMD_IDLE) begin
      active_command_next = head.cmd;
      bit_phase_next      = 2'd0;
      bit_count_next      = 4'd0;
      count_inc           = 4'd1;
      case (head.cmd)
        i2cme_pkg::CMD_WRITE: shift_byte_next = head.write_data;
        i2cme_pkg::CMD_READ:  shift_byte_next = 8'd0;
        i2cme_pkg::CMD_WACK: begin
          poll_count_next   = 8'd0;
          held_ack_next     = 1'b0;
          held_timeout_next = 1'b0;
        end
        default: ;
      endcase
    end

    case (active_command_next)
      i2cme_pkg::CMD_START: begin
        if (bit_phase_next == 2'd0) begin
          data_drive_next = 1'b1;
          data_line_next  = 1'b1;
          clock_line_next = 1'b1;
          bit_phase_next  = 2'd1;
        end else if (bit_phase_next == 2'd1) begin
          data_line_next = 1'b0;
          bit_phase_next = 2'd2;
        end else begin
          clock_line_next = 1'b0;
          done            = 1'b1;
        end
      end
      i2cme_pkg::CMD_STOP: begin
        if (bit_phase_next == 2'd0) begin
          data_drive_next = 1'b1;
          clock_line_next = 1'b0;
          data_line_next  = 1'b0;
          bit_phase_next  = 2'd1;
        end else if (bit_phase_next == 2'd1) begin
          clock_line_next = 1'b1;
          bit_phase_next  = 2'd2;
        end else begin
          data_line_next = 1'b1;
          done           = 1'b1;
        end
      end
      i2cme_pkg::CMD_WRITE: begin
        if (bit_count_next >= i2cme_pkg::BITS_PER_BYTE) begin
          data_line_next  = 1'b1;
          data_drive_next = 1'b0;
          clock_line_next = 1'b1;
          done            = 1'b1;
        end else begin
          data_drive_next = 1'b1;
          case (bit_phase_next)
            2'd0: clock_line_next = 1'b0;
            2'd1: data_line_next  = shift_byte_next[7];
            2'd2: begin
              clock_line_next = 1'b1;
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
            end
            default: begin
              clock_line_next = 1'b0;
              bit_count_next  = count_inc;
            end
          endcase
          bit_phase_next = bit_phase_next + 2'd1;
        end
      end
      i2cme_pkg::CMD_READ: begin
        data_drive_next = 1'b0;
        data_line_next  = 1'b1;
        case (bit_phase_next)
          2'd0: clock_line_next = 1'b0;
          2'd1: clock_line_next = 1'b1;
          2'd2: shift_byte_next = {shift_byte_next[6:0], head.sda_sample};
          default: begin
            clock_line_next = 1'b0;
            bit_count_next  = count_inc;
            if (count_inc >= i2cme_pkg::BITS_PER_BYTE) begin
              held_read_next = shift_byte_next;
              done           = 1'b1;
            end
          end
        endcase
        bit_phase_next = bit_phase_next + 2'd1;
      end
      i2cme_pkg::CMD_WACK: begin
        data_drive_next = 1'b0;
        data_line_next  = 1'b1;
        if (bit_phase_next == 2'd0) begin
          clock_line_next = 1'b1;
          bit_phase_next  = 2'd1;
        end else if (bit_phase_next == 2'd1) begin
          if (!head.sda_sample) begin
            held_ack_next  = 1'b1;
            bit_phase_next = 2'd2;
          end else if (poll_count_next >= ack_wait_limit) begin
            held_timeout_next = 1'b1;
            bit_phase_next    = 2'd2;
          end else begin
            poll_count_next = poll_count_next + 8'd1;
          end
        end else begin
          clock_line_next = 1'b0;
          done            = 1'b1;
        end
      end
      i2cme_pkg::CMD_NACK: begin
        if (bit_phase_next == 2'd0) begin
          data_drive_next = 1'b1;
          data_line_next  = 1'b1;
          clock_line_next = 1'b0;
          bit_phase_next  = 2'd1;
        end else if (bit_phase_next == 2'd1) begin
          clock_line_next = 1'b1;
          bit_phase_next  = 2'd2;
        end else begin
          clock_line_next = 1'b0;
          done            = 1'b1;
        end
      end
      default: active_command_next = i2cme_pkg::CMD_IDLE;
    endcase

    if (done) begin
      active_command_next = i2cme_pkg::CMD_IDLE;
      bit_phase_next      = 2'd0;
      bit_count_next      = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit <= i2cme_pkg::ACK_LIMIT_RESET;
    end else if (cfg_write_enable) begin
      ack_wait_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= i2cme_pkg::CMD_IDLE;
      bit_phase      <= 2'd0;
      bit_count      <= 4'd0;
      shift_byte     <= 8'd0;
      poll_count     <= 8'd0;
      clock_line     <= 1'b1;
      data_line      <= 1'b1;
      data_drive     <= 1'b1;
      held_read      <= 8'd0;
      held_ack       <= 1'b0;
      held_timeout   <= 1'b0;
    end else if (pop) begin
      active_command <= active_command_next;
      bit_phase      <= bit_phase_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      poll_count     <= poll_count_next;
      clock_line     <= clock_line_next;
      data_line      <= data_line_next;
      data_drive     <= data_drive_next;
      held_read      <= held_read_next;
      held_ack       <= held_ack_next;
      held_timeout   <= held_timeout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.scl_level        <= clock_line_next;
      rsp.sda_level        <= data_line_next;
      rsp.sda_drive_enable <= data_drive_next;
      rsp.busy_res         <= (active_command_next != i2cme_pkg::CMD_IDLE);
      rsp.done_res         <= done;
      rsp.read_data        <= held_read_next;
      rsp.ack_seen         <= held_ack_next;
      rsp.ack_timed_out    <= held_timeout_next;
    end
  end

endmodule

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: front decode, tick queue and bus sequencer.
//
// This block is a tick-driven I2C master. Every transaction on the req channel is one
// bus timing tick: it carries an optional command (start, stop, write byte, read byte,
// wait for acknowledge, send not-acknowledge) and the SDA level sampled on that tick,
// and it produces exactly one transaction on the rsp channel with the SCL level, the SDA
// level and drive enable, busy and done flags, the last read byte and the result of the
// last acknowledge wait. A command is only taken while no command is running; modes
// given while busy are ignored, as are modes none and seven. The sustained rate is one
// tick per clock cycle when nothing stalls. On its way from req to rsp a tick passes
// through the decode register of the front and the two-entry tick queue, and the
// sequencer then writes its response into its output register. The sequencer carries
// out one tick per cycle whenever a tick is queued and its output register is free or
// being emptied; the queue absorbs short output stalls, but a longer one fills it and
// stalls the input. The acknowledge timeout, in ticks, is written through
// cfg_write_enable and cfg_write_data (reset value 250); it should only be changed while
// no transaction is in flight.

`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_enable,
  input  logic [7:0]      cfg_write_data,
  input  logic            req_valid,
  output logic            req_ready,
  input  i2cme_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output i2cme_pkg::rsp_t rsp
);

  // Decoded ticks travel from the front into the queue.
  logic                 push;
  i2cme_pkg::tick_t     push_tick;

  // The back drains the queue one tick per cycle while its output register is free or being emptied.
  logic                 pop;
  i2cme_pkg::tick_t     head;
  i2cme_pkg::q_status_t q_status;

  i2cme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_tick (push_tick)
  );

  i2cme_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tick (push_tick),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  i2cme_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .head             (head),
    .q_status         (q_status),
    .pop              (pop),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .rsp              (rsp)
  );

  // A finished command has already left the sequencer, so it cannot still be busy.
  `IME_ASSERT_IMPLY(a_done_not_busy, clk, rst, rsp_valid && rsp.done_res, !rsp.busy_res, "done while busy")

  // An acknowledge wait ends either with an acknowledge or with a timeout, never both.
  `IME_ASSERT_IMPLY(a_ack_exclusive, clk, rst, rsp_valid, !(rsp.ack_seen && rsp.ack_timed_out), "ack and timeout both set")

  // A released SDA line always reads as high on the level output.
  `IME_ASSERT_IMPLY(a_released_high, clk, rst, rsp_valid && !rsp.sda_drive_enable, rsp.sda_level, "released SDA not high")

  // The queue never takes a tick when it is full.
  `IME_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !q_status.full, "queue overflow")

endmodule

// ===== tb/i2c_master_byte_engine_tb.sv =====
// Self-checking testbench for the I2C master byte engine with a tick-level scoreboard.
module i2c_master_byte_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode seven has no command behind it; the engine must treat it like mode none.
  localparam logic [2:0] MODE_UNUSED  = 3'd7;
  localparam int         IDLE_PCT     = 35;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         RANDOM_TICKS = 270;
  localparam int         PHASE_TICKS  = 55;
  localparam int         HOLD_CYCLES  = 60;
  localparam int         MAX_REPORTS  = 10;

  // Tracks the bus sequencer tick by tick and keeps the responses it should produce.
  class i2c_tick_scoreboard;
    i2cme_pkg::rsp_t expected_q[$];
    i2cme_pkg::cmd_t active;
    logic [1:0]      bit_step;
    logic [3:0]      bits_done;
    logic [7:0]      shifter;
    logic [7:0]      polls;
    logic [7:0]      ack_limit;
    logic            scl;
    logic            sda;
    logic            sda_drive;
    logic [7:0]      last_read;
    logic            ack_flag;
    logic            timeout_flag;
    int              failures;
    int              checked;
    int              started[8];
    int              acks;
    int              timeouts;

    function new();
      active       = i2cme_pkg::CMD_IDLE;
      bit_step     = '0;
      bits_done    = '0;
      shifter      = '0;
      polls        = '0;
      ack_limit    = i2cme_pkg::ACK_LIMIT_RESET;
      scl          = 1'b1;
      sda          = 1'b1;
      sda_drive    = 1'b1;
      last_read    = '0;
      ack_flag     = 1'b0;
      timeout_flag = 1'b0;
      failures     = 0;
      checked      = 0;
      acks         = 0;
      timeouts     = 0;
      foreach (started[i]) started[i] = 0;
    endfunction

    function void set_limit(logic [7:0] value);
      ack_limit = value;
    endfunction

    function bit busy();
      return active != i2cme_pkg::CMD_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advances the sequencer by one accepted tick and queues the response it yields.
    function void note_tick(i2cme_pkg::req_t tick);
      i2cme_pkg::rsp_t result;
      logic finished;
      finished = 1'b0;

      // A command is only taken while idle; anything else in the mode field is ignored.
      if (active == i2cme_pkg::CMD_IDLE && tick.mode >= i2cme_pkg::MODE_START &&
          tick.mode <= i2cme_pkg::MODE_NACK) begin
        active    = i2cme_pkg::cmd_t'(tick.mode);
        bit_step  = '0;
        bits_done = '0;
        started[tick.mode]++;
        if (tick.mode == i2cme_pkg::MODE_WRITE) begin
          shifter = tick.write_data;
        end else if (tick.mode == i2cme_pkg::MODE_READ) begin
          shifter = '0;
        end else if (tick.mode == i2cme_pkg::MODE_WACK) begin
          polls        = '0;
          ack_flag     = 1'b0;
          timeout_flag = 1'b0;
        end
      end

      case (active)
        i2cme_pkg::CMD_START: begin
          if (bit_step == 2'd0) begin
            sda_drive = 1'b1; sda = 1'b1; scl = 1'b1; bit_step = 2'd1;
          end else if (bit_step == 2'd1) begin
            sda = 1'b0; bit_step = 2'd2;
          end else begin
            scl = 1'b0; finished = 1'b1;
          end
        end
        i2cme_pkg::CMD_STOP: begin
          // SDA rises only on the tick after SCL has gone high.
          if (bit_step == 2'd0) begin
            sda_drive = 1'b1; scl = 1'b0; sda = 1'b0; bit_step = 2'd1;
          end else if (bit_step == 2'd1) begin
            scl = 1'b1; bit_step = 2'd2;
          end else begin
            sda = 1'b1; finished = 1'b1;
          end
        end
        i2cme_pkg::CMD_WRITE: begin
          if (bits_done >= i2cme_pkg::BITS_PER_BYTE) begin
            sda = 1'b1; sda_drive = 1'b0; scl = 1'b1; finished = 1'b1;
          end else begin
            sda_drive = 1'b1;
            case (bit_step)
              2'd0: scl = 1'b0;
              2'd1: sda = shifter[7];
              2'd2: begin
                scl     = 1'b1;
                shifter = {shifter[6:0], 1'b0};
              end
              default: begin
                scl       = 1'b0;
                bits_done = bits_done + 4'd1;
              end
            endcase
            bit_step = bit_step + 2'd1;
          end
        end
        i2cme_pkg::CMD_READ: begin
          sda_drive = 1'b0;
          sda       = 1'b1;
          case (bit_step)
            2'd0: scl = 1'b0;
            2'd1: scl = 1'b1;
            2'd2: shifter = {shifter[6:0], tick.sda_sample};
            default: begin
              scl       = 1'b0;
              bits_done = bits_done + 4'd1;
              if (bits_done >= i2cme_pkg::BITS_PER_BYTE) begin
                last_read = shifter;
                finished  = 1'b1;
              end
            end
          endcase
          bit_step = bit_step + 2'd1;
        end
        i2cme_pkg::CMD_WACK: begin
          sda_drive = 1'b0;
          sda       = 1'b1;
          if (bit_step == 2'd0) begin
            scl = 1'b1; bit_step = 2'd1;
          end else if (bit_step == 2'd1) begin
            // A low SDA wins over the limit; a zero limit still polls once.
            if (!tick.sda_sample) begin
              ack_flag = 1'b1; bit_step = 2'd2; acks++;
            end else if (polls >= ack_limit) begin
              timeout_flag = 1'b1; bit_step = 2'd2; timeouts++;
            end else begin
              polls = polls + 8'd1;
            end
          end else begin
            scl = 1'b0; finished = 1'b1;
          end
        end
        i2cme_pkg::CMD_NACK: begin
          if (bit_step == 2'd0) begin
            sda_drive = 1'b1; sda = 1'b1; scl = 1'b0; bit_step = 2'd1;
          end else if (bit_step == 2'd1) begin
            scl = 1'b1; bit_step = 2'd2;
          end else begin
            scl = 1'b0; finished = 1'b1;
          end
        end
        default: active = i2cme_pkg::CMD_IDLE;
      endcase

      if (finished) begin
        active    = i2cme_pkg::CMD_IDLE;
        bit_step  = '0;
        bits_done = '0;
      end

      result.scl_level        = scl;
      result.sda_level        = sda;
      result.sda_drive_enable = sda_drive;
      result.busy_res         = (active != i2cme_pkg::CMD_IDLE);
      result.done_res         = finished;
      result.read_data        = last_read;
      result.ack_seen         = ack_flag;
      result.ack_timed_out    = timeout_flag;
      expected_q.push_back(result);
    endfunction

    function string show(i2cme_pkg::rsp_t r);
      return $sformatf("scl=%0b sda=%0b drv=%0b busy=%0b done=%0b rd=%02h ack=%0b tmo=%0b",
                       r.scl_level, r.sda_level, r.sda_drive_enable, r.busy_res,
                       r.done_res, r.read_data, r.ack_seen, r.ack_timed_out);
    endfunction

    // Compares one response with the oldest expectation, field by field.
    function void check_result(i2cme_pkg::rsp_t got);
      i2cme_pkg::rsp_t want;
      string           diff;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("Unexpected response with nothing pending: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      diff = "";
      if (got.scl_level        !== want.scl_level)        diff = {diff, " scl_level"};
      if (got.sda_level        !== want.sda_level)        diff = {diff, " sda_level"};
      if (got.sda_drive_enable !== want.sda_drive_enable) diff = {diff, " sda_drive_enable"};
      if (got.busy_res         !== want.busy_res)         diff = {diff, " busy_res"};
      if (got.done_res         !== want.done_res)         diff = {diff, " done_res"};
      if (got.read_data        !== want.read_data)        diff = {diff, " read_data"};
      if (got.ack_seen         !== want.ack_seen)         diff = {diff, " ack_seen"};
      if (got.ack_timed_out    !== want.ack_timed_out)    diff = {diff, " ack_timed_out"};
      if (diff != "") begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("Mismatch on response %0d:%s", checked, diff);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
      checked++;
    endfunction
  endclass

  logic            clk              = 1'b0;
  logic            rst              = 1'b1;
  logic            cfg_write_enable = 1'b0;
  logic [7:0]      cfg_write_data   = 8'd0;
  logic            req_valid        = 1'b0;
  i2cme_pkg::req_t req              = '0;
  logic            rsp_ready        = 1'b0;
  logic            req_ready;
  logic            rsp_valid;
  i2cme_pkg::rsp_t rsp;

  i2c_tick_scoreboard sb;
  int ticks_sent;
  int limits_written;
  bit no_idle;
  bit hold_request;

  i2c_master_byte_engine u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .rsp              (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Response side: checks every response transaction and throttles rsp_ready. One long
  // hold-off, requested by the stimulus, lets the engine fill up and stall its input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no transaction for %0d cycles", quiet);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic sda_pick(int low_pct);
    return $urandom_range(99) >= low_pct;
  endfunction

  // Presents one tick after an optional random gap and returns at the edge that takes it.
  // The caller must present the next tick or lower valid in that same time step.
  task automatic send_tick(input logic [2:0] mode, input logic [7:0] data,
                           input logic sample);
    int              gap;
    i2cme_pkg::req_t item;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.mode       = mode;
    item.write_data = data;
    item.sda_sample = sample;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    sb.note_tick(item);
    ticks_sent++;
  endtask

  // Issues one command and keeps ticking until it completes. Ticks sent while the engine
  // is busy carry random modes, which must all be ignored.
  task automatic run_cmd(input logic [2:0] mode, input logic [7:0] data, input int low_pct);
    send_tick(mode, data, sda_pick(low_pct));
    while (sb.busy())
      send_tick(3'($urandom_range(7)), 8'($urandom), sda_pick(low_pct));
  endtask

  // Waits until the engine is empty, then writes the acknowledge limit.
  task automatic drain_and_set_limit(input logic [7:0] value);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    sb.set_limit(value);
    limits_written++;
  endtask

  initial begin
    int         random_start;
    int         phase_start;
    int         noise;
    int         phase;
    int         low_pct;
    logic [2:0] mode;
    logic [7:0] limit;

    sb             = new();
    ticks_sent     = 0;
    limits_written = 0;
    no_idle        = 1'b0;
    hold_request   = 1'b0;
    noise          = 0;
    phase          = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset limit: ignored modes, every command, byte extremes,
    // a command offered while busy, and an acknowledge on the first poll.
    send_tick(i2cme_pkg::MODE_NONE, 8'hFF, 1'b0);
    send_tick(MODE_UNUSED, 8'h00, 1'b1);
    run_cmd(i2cme_pkg::MODE_START, 8'h00, 50);
    run_cmd(i2cme_pkg::MODE_WRITE, 8'hFF, 50);
    run_cmd(i2cme_pkg::MODE_WRITE, 8'h00, 50);
    run_cmd(i2cme_pkg::MODE_READ, 8'h00, 0);
    run_cmd(i2cme_pkg::MODE_READ, 8'hFF, 100);
    run_cmd(i2cme_pkg::MODE_WACK, 8'h00, 100);
    run_cmd(i2cme_pkg::MODE_NACK, 8'h00, 50);
    run_cmd(i2cme_pkg::MODE_STOP, 8'h00, 50);

    // A zero limit polls once and then times out; a small limit runs the full poll.
    drain_and_set_limit(8'd0);
    run_cmd(i2cme_pkg::MODE_WACK, 8'h00, 0);
    drain_and_set_limit(8'd3);
    run_cmd(i2cme_pkg::MODE_WACK, 8'h00, 0);

    // Random phases, each at its own limit. Most ticks belong to well-formed commands;
    // a share are stray modes offered while idle.
    random_start = ticks_sent;
    while (ticks_sent - random_start - noise < RANDOM_TICKS) begin
      case (phase % 5)
        0:       limit = 8'd1;
        1:       limit = 8'($urandom_range(2, 15));
        2:       limit = 8'hFF;
        3:       limit = 8'd0;
        default: limit = 8'($urandom);
      endcase
      drain_and_set_limit(limit);
      no_idle = (phase == 2);
      if (phase == 1) hold_request = 1'b1;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        if ($urandom_range(99) < 12) begin
          mode = $urandom_range(1) ? i2cme_pkg::MODE_NONE : MODE_UNUSED;
          send_tick(mode, 8'($urandom), 1'($urandom));
          noise++;
        end else begin
          mode = 3'($urandom_range(i2cme_pkg::MODE_START, i2cme_pkg::MODE_NACK));
          low_pct = 50;
          if (mode == i2cme_pkg::MODE_WACK) begin
            case ($urandom_range(3))
              0:       low_pct = 100;
              1:       low_pct = 50;
              2:       low_pct = 10;
              default: low_pct = (limit > 8'd20) ? 5 : 0;
            endcase
          end
          run_cmd(mode, 8'($urandom), low_pct);
        end
      end
      no_idle = 1'b0;
      phase++;
    end

    // Let every outstanding response come back, then allow a few more cycles for strays.
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d ticks: %0d start, %0d stop, %0d write, %0d read, %0d nack",
             ticks_sent, sb.started[i2cme_pkg::MODE_START], sb.started[i2cme_pkg::MODE_STOP],
             sb.started[i2cme_pkg::MODE_WRITE], sb.started[i2cme_pkg::MODE_READ],
             sb.started[i2cme_pkg::MODE_NACK]);
    $display("Acknowledge waits: %0d (%0d acked, %0d timed out) over %0d limit settings",
             sb.started[i2cme_pkg::MODE_WACK], sb.acks, sb.timeouts, limits_written);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
